// ===== rtl/dpd_pkg.sv =====
// Package for the debug packet deframer: frame phase codes, event codes,
// the result record and the hex digit decoder. No dependencies.
package dpd_pkg;

    // Frame phase codes
    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_PAYLOAD = 2'd1;
    localparam logic [1:0] PH_CK_HI   = 2'd2;
    localparam logic [1:0] PH_CK_LO   = 2'd3;

    // Event codes reported with each item
    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_DATA     = 3'd1;
    localparam logic [2:0] EV_END      = 3'd2;
    localparam logic [2:0] EV_ACK      = 3'd3;
    localparam logic [2:0] EV_RETRY    = 3'd4;
    localparam logic [2:0] EV_INTR     = 3'd5;
    localparam logic [2:0] EV_OVERFLOW = 3'd6;

    // Framing characters
    localparam logic [7:0] CH_ACK    = 8'h2b;
    localparam logic [7:0] CH_RETRY  = 8'h2d;
    localparam logic [7:0] CH_INTR   = 8'h03;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_HASH   = 8'h23;

    localparam int COUNT_OUT_W = 11;

    // Framing state apart from the byte count
    typedef struct packed {
        logic [1:0] phase;
        logic [7:0] sum;
        logic [3:0] hi_nibble;
        logic       hi_valid;
    } dpd_state_t;

    // One result item
    typedef struct packed {
        logic [2:0]             event_kind;
        logic [7:0]             payload_byte;
        logic                   checksum_good;
        logic                   send_ack;
        logic [COUNT_OUT_W-1:0] payload_count;
    } dpd_result_t;

    // Decode an ASCII hex digit: bit 4 high marks a non-hex byte
    function automatic logic [4:0] hex_decode(input logic [7:0] b);
        logic [7:0] v;
        begin
            v = 8'd0;
            if (b inside {[8'h30:8'h39]}) begin
                v = b - 8'h30;
            end else if (b inside {[8'h61:8'h66]}) begin
                v = b - 8'h57;
            end else if (b inside {[8'h41:8'h46]}) begin
                v = b - 8'h37;
            end else begin
                v = 8'h10;
            end
            hex_decode = v[4:0];
        end
    endfunction

endpackage

// ===== rtl/dpd_step.sv =====
// Combinational framing step of the debug packet deframer: next state and
// result for one received byte. Depends on dpd_pkg.
module dpd_step #(
    parameter int MAX_PAYLOAD = 1024,
    parameter int CNT_W       = 11
) (
    input  logic [7:0]             rx_byte,
    input  logic                   ack_mode,
    input  dpd_pkg::dpd_state_t    state_cur,
    input  logic [CNT_W-1:0]       count_cur,
    output dpd_pkg::dpd_state_t    state_next,
    output logic [CNT_W-1:0]       count_next,
    output dpd_pkg::dpd_result_t   result
);
    import dpd_pkg::*;

    logic [4:0]                   digit;
    logic [CNT_W+COUNT_OUT_W-1:0] count_wide;
    logic [COUNT_OUT_W-1:0]       count_out;
    logic                         count_full;

    assign digit      = hex_decode(rx_byte);
    assign count_wide = {{COUNT_OUT_W{1'b0}}, count_cur};
    assign count_out  = count_wide[COUNT_OUT_W-1:0];
    assign count_full = (count_cur >= CNT_W'(MAX_PAYLOAD));

    // Advance the frame phase and build the result
    always_comb begin
        state_next = state_cur;
        count_next = count_cur;
        result     = '0;
        case (state_cur.phase)
            PH_IDLE: begin
                if (rx_byte == CH_ACK) begin
                    result.event_kind = EV_ACK;
                end else if (rx_byte == CH_RETRY) begin
                    result.event_kind = EV_RETRY;
                end else if (rx_byte == CH_INTR) begin
                    result.event_kind = EV_INTR;
                end else if (rx_byte == CH_DOLLAR) begin
                    state_next.phase     = PH_PAYLOAD;
                    state_next.sum       = 8'd0;
                    state_next.hi_nibble = 4'd0;
                    state_next.hi_valid  = 1'b0;
                    count_next           = '0;
                end
            end
            PH_PAYLOAD: begin
                if (rx_byte == CH_HASH) begin
                    state_next.phase = PH_CK_HI;
                end else if (count_full) begin
                    // drop the packet on overrun
                    result.event_kind    = EV_OVERFLOW;
                    result.payload_count = count_out;
                    state_next.phase     = PH_IDLE;
                end else begin
                    state_next.sum       = state_cur.sum + rx_byte;
                    count_next           = count_cur + 1'b1;
                    result.event_kind    = EV_DATA;
                    result.payload_byte  = rx_byte;
                end
            end
            PH_CK_HI: begin
                state_next.hi_valid  = ~digit[4];
                state_next.hi_nibble = digit[3:0];
                state_next.phase     = PH_CK_LO;
            end
            PH_CK_LO: begin
                result.event_kind    = EV_END;
                result.checksum_good = state_cur.hi_valid && !digit[4] &&
                                       ({state_cur.hi_nibble, digit[3:0]} == state_cur.sum);
                result.send_ack      = ack_mode;
                result.payload_count = count_out;
                state_next.phase     = PH_IDLE;
            end
            default: begin
                state_next.phase = PH_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/debug_packet_deframer_top.sv =====
// Debug packet deframer: one received byte in, one result item out.
// Each accepted byte passes through the input register, the framing step and then
// the result register. Throughput: one item per cycle while m_ready is high; a
// stalled result register holds the input register, and s_ready drops once it is full.
// Reset (aresetn, synchronous, active low): idle phase, sum and count zero,
// acknowledge mode on, both registers empty.
module debug_packet_deframer_top #(
    parameter int MAX_PAYLOAD = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_event_kind,
    output logic [7:0]  m_payload_byte,
    output logic        m_checksum_good,
    output logic        m_send_ack,
    output logic [10:0] m_payload_count,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);
    import dpd_pkg::*;

    localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);

    logic             in_valid_reg, in_valid_next;
    logic [7:0]       in_byte_reg;
    logic             out_valid_reg, out_valid_next;
    dpd_result_t      out_reg;
    dpd_state_t       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ack_mode_reg;
    dpd_result_t      step_result;
    logic             step_fire;
    logic             s_fire;

    // Move an item to the result register when it is free or being drained
    assign step_fire = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || step_fire;
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    assign in_valid_next  = s_fire || (in_valid_reg && !step_fire);
    assign out_valid_next = step_fire || (out_valid_reg && !m_ready);

    dpd_step #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .CNT_W       (CNT_W)
    ) u_step (
        .rx_byte    (in_byte_reg),
        .ack_mode   (ack_mode_reg),
        .state_cur  (state_reg),
        .count_cur  (count_reg),
        .state_next (state_next),
        .count_next (count_next),
        .result     (step_result)
    );

    // Control state and framing state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
            count_reg     <= '0;
            ack_mode_reg  <= 1'b1;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (step_fire) begin
                state_reg <= state_next;
                count_reg <= count_next;
            end
            if (cfg_valid) begin
                ack_mode_reg <= cfg_data;
            end
        end
    end

    // Payload registers: hold until the next item moves in
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_byte_reg <= s_rx_byte;
        end
        if (step_fire) begin
            out_reg <= step_result;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_event_kind    = out_reg.event_kind;
    assign m_payload_byte  = out_reg.payload_byte;
    assign m_checksum_good = out_reg.checksum_good;
    assign m_send_ack      = out_reg.send_ack;
    assign m_payload_count = out_reg.payload_count;

endmodule

// ===== tb/tb_debug_packet_deframer_top.sv =====
// Self-checking testbench for debug_packet_deframer_top: drives a received byte stream,
// predicts every result item in-line and checks each one field by field.
// Depends on dpd_pkg (codes, framing characters, result record) and the RTL top level.
module tb_debug_packet_deframer_top;
    import dpd_pkg::*;

    localparam int PKT_LIMIT   = 1024;
    localparam int LONG_HOLD   = 250;
    localparam int STALL_LIMIT = 4000;
    localparam int TAIL_CYCLES = 8;

    typedef enum int {CK_LOWER, CK_UPPER, CK_WRONG, CK_JUNK} ck_style_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic [7:0]  s_rx_byte = 8'h00;
    logic        m_ready   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_data  = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic [2:0]  m_event_kind;
    logic [7:0]  m_payload_byte;
    logic        m_checksum_good;
    logic        m_send_ack;
    logic [10:0] m_payload_count;
    logic        cfg_ready;

    // Framing state of the predictor
    logic [1:0]  fr_phase  = PH_IDLE;
    logic [7:0]  fr_sum    = 8'h00;
    logic [3:0]  fr_hi     = 4'h0;
    logic        fr_hi_ok  = 1'b0;
    int unsigned fr_count  = 0;
    logic        ack_mode  = 1'b1;

    dpd_result_t pending_results[$];

    bit          tx_stall_en  = 1'b1;
    bit          rx_stall_en  = 1'b1;
    bit          hold_request = 1'b0;
    bit          hold_active  = 1'b0;
    int          err_count    = 0;
    int unsigned items_sent   = 0;
    int unsigned results_seen = 0;
    int unsigned kind_seen [8];
    int unsigned good_ends    = 0;
    int unsigned cfg_writes   = 0;
    int          idle_cycles  = 0;

    debug_packet_deframer_top #(
        .MAX_PAYLOAD(PKT_LIMIT)
    ) u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_event_kind   (m_event_kind),
        .m_payload_byte (m_payload_byte),
        .m_checksum_good(m_checksum_good),
        .m_send_ack     (m_send_ack),
        .m_payload_count(m_payload_count),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Value of an ASCII hex digit; bit 4 flags a byte that is no digit
    function automatic logic [4:0] digit_value(input logic [7:0] b);
        if (b >= 8'h30 && b <= 8'h39) begin
            return {1'b0, b[3:0]};
        end
        if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
            return {1'b0, b[3:0] + 4'd9};
        end
        return 5'h10;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit upper);
        if (nib < 4'd10) begin
            return 8'h30 + nib;
        end
        return (upper ? 8'h41 : 8'h61) + nib - 8'd10;
    endfunction

    function automatic logic [7:0] rand_payload_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == CH_HASH) begin
            b = b + 8'd1;
        end
        return b;
    endfunction

    // Advance the framing state by one byte and return the result it causes
    function automatic dpd_result_t frame_step(input logic [7:0] b);
        dpd_result_t r;
        logic [4:0]  d;
        r = '0;
        r.event_kind = EV_NONE;
        case (fr_phase)
            PH_IDLE: begin
                if (b == CH_ACK) begin
                    r.event_kind = EV_ACK;
                end else if (b == CH_RETRY) begin
                    r.event_kind = EV_RETRY;
                end else if (b == CH_INTR) begin
                    r.event_kind = EV_INTR;
                end else if (b == CH_DOLLAR) begin
                    fr_phase = PH_PAYLOAD;
                    fr_sum   = 8'h00;
                    fr_count = 0;
                    fr_hi    = 4'h0;
                    fr_hi_ok = 1'b0;
                end
            end
            PH_PAYLOAD: begin
                if (b == CH_HASH) begin
                    fr_phase = PH_CK_HI;
                end else if (fr_count >= PKT_LIMIT) begin
                    // drop the packet once it runs past the size limit
                    r.event_kind    = EV_OVERFLOW;
                    r.payload_count = 11'(fr_count);
                    fr_phase        = PH_IDLE;
                end else begin
                    fr_sum         = fr_sum + b;
                    fr_count       = fr_count + 1;
                    r.event_kind   = EV_DATA;
                    r.payload_byte = b;
                end
            end
            PH_CK_HI: begin
                d        = digit_value(b);
                fr_hi_ok = !d[4];
                fr_hi    = d[3:0];
                fr_phase = PH_CK_LO;
            end
            default: begin
                d               = digit_value(b);
                r.event_kind    = EV_END;
                r.checksum_good = fr_hi_ok && !d[4] && ({fr_hi, d[3:0]} == fr_sum);
                r.send_ack      = ack_mode;
                r.payload_count = 11'(fr_count);
                fr_phase        = PH_IDLE;
                if (r.checksum_good) begin
                    good_ends++;
                end
            end
        endcase
        kind_seen[r.event_kind]++;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [10:0] got,
                                   input logic [10:0] want);
        $display("MISMATCH result %0d: %s got %0h expected %0h", results_seen, what, got, want);
        err_count++;
    endtask

    // Offer one byte, hold it until taken, then record what it must produce
    task automatic send_byte(input logic [7:0] b);
        if (tx_stall_en && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!(s_valid && s_ready));
        pending_results.push_back(frame_step(b));
        items_sent++;
    endtask

    // Stop offering and wait until every expected result has come back
    task automatic wait_drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    task automatic write_ack_mode(input logic v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        ack_mode = v;
        cfg_writes++;
        cfg_valid <= 1'b0;
    endtask

    task automatic send_packet(input int len, input ck_style_t style);
        logic [7:0] b;
        logic [7:0] sum;
        sum = 8'h00;
        send_byte(CH_DOLLAR);
        repeat (len) begin
            b   = rand_payload_byte();
            sum = sum + b;
            send_byte(b);
        end
        send_byte(CH_HASH);
        case (style)
            CK_LOWER, CK_UPPER: begin
                send_byte(hex_char(sum[7:4], style == CK_UPPER));
                send_byte(hex_char(sum[3:0], style == CK_UPPER));
            end
            CK_WRONG: begin
                sum = sum + 8'($urandom_range(1, 255));
                send_byte(hex_char(sum[7:4], 1'b0));
                send_byte(hex_char(sum[3:0], 1'b1));
            end
            default: begin
                send_byte(8'($urandom_range(0, 255)));
                send_byte(8'($urandom_range(0, 255)));
            end
        endcase
    endtask

    task automatic test_between_packets();
        send_byte(8'h00);
        send_byte(CH_HASH);
        send_byte(8'h7a);
        send_byte(CH_ACK);
        send_byte(CH_RETRY);
        send_byte(CH_INTR);
    endtask

    // Empty packet with acknowledge mode off, then back on
    task automatic test_empty_packet();
        wait_drain();
        write_ack_mode(1'b0);
        send_byte(CH_DOLLAR);
        send_byte(CH_HASH);
        send_byte(8'h30);
        send_byte(8'h30);
        wait_drain();
        write_ack_mode(1'b1);
    endtask

    // Byte extremes in the payload, checksum digits in both cases
    task automatic test_mixed_case_checksum();
        send_byte(CH_DOLLAR);
        send_byte(8'hff);
        send_byte(8'h00);
        send_byte(CH_HASH);
        send_byte(8'h46);
        send_byte(8'h66);
    endtask

    task automatic test_dollar_in_payload();
        send_byte(CH_DOLLAR);
        send_byte(CH_DOLLAR);
        send_byte(CH_HASH);
        send_byte(8'h32);
        send_byte(8'h34);
    endtask

    // Non-hex digit in the high and in the low checksum position
    task automatic test_bad_checksums();
        send_byte(CH_DOLLAR);
        send_byte(CH_HASH);
        send_byte(8'h67);
        send_byte(8'h30);
        send_byte(CH_DOLLAR);
        send_byte(CH_HASH);
        send_byte(8'h30);
        send_byte(8'h47);
    endtask

    // Mostly well-formed packets, with control bytes and noise between them
    task automatic test_random_traffic(input int n_items);
        int unsigned goal;
        int          pick;
        int          len;
        goal = items_sent + n_items;
        while (items_sent < goal) begin
            case ($urandom_range(0, 9))
                0: begin
                    repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
                end
                1: begin
                    repeat ($urandom_range(1, 3)) begin
                        case ($urandom_range(0, 2))
                            0:       send_byte(CH_ACK);
                            1:       send_byte(CH_RETRY);
                            default: send_byte(CH_INTR);
                        endcase
                    end
                end
                default: begin
                    pick = $urandom_range(0, 99);
                    if (pick < 85) begin
                        len = $urandom_range(0, 16);
                    end else if (pick < 97) begin
                        len = $urandom_range(17, 64);
                    end else begin
                        len = $urandom_range(65, 200);
                    end
                    pick = $urandom_range(0, 9);
                    if (pick < 4) begin
                        send_packet(len, CK_LOWER);
                    end else if (pick < 7) begin
                        send_packet(len, CK_UPPER);
                    end else if (pick < 9) begin
                        send_packet(len, CK_WRONG);
                    end else begin
                        send_packet(len, CK_JUNK);
                    end
                end
            endcase
        end
    endtask

    // Hold off the receiver while the sender keeps offering without pauses, then drain
    task automatic test_backpressure();
        bit saved_stall;
        saved_stall  = tx_stall_en;
        tx_stall_en  = 1'b0;
        hold_request = 1'b1;
        s_valid <= 1'b0;
        do @(posedge aclk); while (!hold_active);
        repeat (3) send_packet(12, CK_LOWER);
        wait_drain();
        tx_stall_en = saved_stall;
    endtask

    // One packet that runs one byte past the limit; the overflow item carries the full count
    task automatic test_payload_limit();
        send_byte(CH_DOLLAR);
        repeat (PKT_LIMIT + 1) send_byte(rand_payload_byte());
        send_byte(CH_HASH);
        send_byte(8'h30);
        send_byte(8'h30);
    endtask

    // Receiver: random ready and stall bursts, or one long hold on request
    initial begin : drive_ready
        int span;
        @(posedge aclk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                hold_active  = 1'b1;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_active = 1'b0;
            end else if (rx_stall_en && $urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                span = $urandom_range(1, 10);
                repeat (span) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                span = rx_stall_en ? $urandom_range(1, 16) : 1;
                repeat (span) @(posedge aclk);
            end
        end
    end

    // Compare each result item with the oldest expectation
    always @(posedge aclk) begin : check_results
        dpd_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing expected, event_kind",
                                11'(m_event_kind), '0);
            end else begin
                want = pending_results.pop_front();
                if (m_event_kind !== want.event_kind) begin
                    report_mismatch("event_kind", 11'(m_event_kind),
                                    11'(want.event_kind));
                end
                if (m_payload_byte !== want.payload_byte) begin
                    report_mismatch("payload_byte", 11'(m_payload_byte),
                                    11'(want.payload_byte));
                end
                if (m_checksum_good !== want.checksum_good) begin
                    report_mismatch("checksum_good", 11'(m_checksum_good),
                                    11'(want.checksum_good));
                end
                if (m_send_ack !== want.send_ack) begin
                    report_mismatch("send_ack", 11'(m_send_ack), 11'(want.send_ack));
                end
                if (m_payload_count !== want.payload_count) begin
                    report_mismatch("payload_count", m_payload_count, want.payload_count);
                end
            end
            results_seen++;
        end
    end

    // Watchdog: end the run when no item moves on any channel for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", idle_cycles);
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : run_tests
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_between_packets();
        test_empty_packet();
        test_mixed_case_checksum();
        test_dollar_in_payload();
        test_bad_checksums();

        for (int ph = 0; ph < 4; ph++) begin
            wait_drain();
            write_ack_mode(ph[0]);
            test_random_traffic(150);
        end
        test_backpressure();
        write_ack_mode(1'b1);
        test_payload_limit();

        // last stretch at full rate on both sides
        tx_stall_en = 1'b0;
        rx_stall_en = 1'b0;
        wait_drain();
        write_ack_mode(1'b0);
        test_random_traffic(100);

        wait_drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("run covered %0d bytes and %0d results, %0d register writes",
                 items_sent, results_seen, cfg_writes);
        $display("packet ends %0d (%0d good), payload %0d, ack/retry/intr %0d/%0d/%0d",
                 kind_seen[EV_END], good_ends, kind_seen[EV_DATA], kind_seen[EV_ACK],
                 kind_seen[EV_RETRY], kind_seen[EV_INTR]);
        $display("overflow %0d", kind_seen[EV_OVERFLOW]);
        if (err_count == 0 && pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
